>>> rtl/core/ecpa_pkg.sv
// ----------------------------------------------------------------------------
// Elliptic-curve point unit package
// Shared widths, payload words, sequencer states and field helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ecpa_pkg;

  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned SCALAR_BITS = 16;
  localparam int unsigned FCNT_BITS   = $clog2(FIELD_BITS);
  localparam int unsigned SCNT_BITS   = $clog2(SCALAR_BITS);

  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = FIELD_BITS'(163);
  localparam logic [FIELD_BITS-1:0] CURVE_A_RESET = FIELD_BITS'(1);

  typedef enum logic {
    REG_MODULUS = 1'b0,
    REG_CURVE_A = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_MUL = 1'b1
  } opcode_e;

  typedef struct packed {
    logic                   opcode;
    logic [FIELD_BITS-1:0]  p_x;
    logic [FIELD_BITS-1:0]  p_y;
    logic [FIELD_BITS-1:0]  q_x;
    logic [FIELD_BITS-1:0]  q_y;
    logic [SCALAR_BITS-1:0] scalar;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] result_x;
    logic [FIELD_BITS-1:0] result_y;
    logic                  at_infinity;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED_SET,
    S_RED_STORE,
    S_OP_SEL,
    S_LOOP,
    S_ADD_DONE,
    S_DBL_SET,
    S_DBL_DONE,
    S_PA_START,
    S_PA_DBL2,
    S_PA_DBL3,
    S_PA_DEN,
    S_INV_INIT,
    S_INV_SQ,
    S_INV_SQD,
    S_INV_MD,
    S_SLOPE,
    S_SQ,
    S_X1,
    S_X2D,
    S_X2A,
    S_Y1,
    S_Y2,
    S_MUL,
    S_FIN
  } state_e;

  function automatic logic [FIELD_BITS-1:0] fsub(input logic [FIELD_BITS-1:0] a,
                                                 input logic [FIELD_BITS-1:0] b,
                                                 input logic [FIELD_BITS-1:0] m);
    logic [FIELD_BITS-1:0] r;
    r = a - b;
    if (a < b) begin
      r = r + m;
    end
    return r;
  endfunction

  function automatic logic [FIELD_BITS-1:0] fadd(input logic [FIELD_BITS-1:0] a,
                                                 input logic [FIELD_BITS-1:0] b,
                                                 input logic [FIELD_BITS-1:0] m);
    logic [FIELD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[FIELD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ec_point_add_scalar_multiply.sv
// ----------------------------------------------------------------------------
// Elliptic-curve point add and scalar multiply
// Affine point arithmetic over a prime field on one shared modular multiplier.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                               | Word
//  --------+---------------------------------------+------------
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i       | register
//  input   | in_valid_i, in_ready_o, in_word_i     | in_word_t
//  output  | out_valid_o, out_ready_i, out_word_o  | out_word_t
//
// Each modular multiply runs on the bit-serial multiplier.
// A point addition takes up to about 40 multiplies (inversion by exponentiation);
// a multiply word takes up to about 2 * SCALAR_BITS point operations.
// Reset restores the register defaults and empties the output stage.
// A new word is taken only when the sequencer is idle; a finished result waits
// in the output register while the input side is free again.
`default_nettype none

module ec_point_add_scalar_multiply import ecpa_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [FIELD_BITS-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire in_word_t              in_word_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      out_word_t             out_word_o
);

  localparam logic [FIELD_BITS-1:0] ONE   = FIELD_BITS'(1);
  localparam logic [FIELD_BITS-1:0] TWO   = FIELD_BITS'(2);
  localparam logic [FIELD_BITS-1:0] THREE = FIELD_BITS'(3);

  state_e state_q, state_d, mret_q, mret_d, pret_q, pret_d;

  logic [FIELD_BITS-1:0] mod_q, crv_q;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q, out_d;
  in_word_t              in_q, in_d;

  logic [FIELD_BITS-1:0] ar_q, ar_d, px_q, px_d, py_q, py_d, qx_q, qx_d, qy_q, qy_d;
  logic [FIELD_BITS-1:0] resx_q, resx_d, resy_q, resy_d, runx_q, runx_d, runy_q, runy_d;
  logic [FIELD_BITS-1:0] ux_q, ux_d, uy_q, uy_d, vx_q, vx_d, vy_q, vy_d;
  logic [FIELD_BITS-1:0] wx_q, wx_d, wy_q, wy_d;
  logic [FIELD_BITS-1:0] num_q, num_d, den_q, den_d, inv_q, inv_d, s_q, s_d, t_q, t_d;
  logic [FIELD_BITS-1:0] ma_q, ma_d, mb_q, mb_d, mr_q, mr_d;
  logic [FCNT_BITS-1:0]  mcnt_q, mcnt_d, j_q, j_d;
  logic [SCNT_BITS-1:0]  i_q, i_d;
  logic [2:0]            ridx_q, ridx_d;
  logic                  dbl_q, dbl_d, bad_q, bad_d;

  logic [FIELD_BITS-1:0] mstep, raw_sel, exp_m2;
  logic                  u_inf, v_inf, opp, same;

  assign exp_m2 = mod_q - TWO;
  assign u_inf  = (ux_q == '0) && (uy_q == '0);
  assign v_inf  = (vx_q == '0) && (vy_q == '0);
  assign opp    = (ux_q == vx_q) && (uy_q == fsub('0, vy_q, mod_q));
  assign same   = (ux_q == vx_q) && (uy_q == vy_q);

  always_comb begin
    mstep = fadd(mr_q, mr_q, mod_q);
    if (mb_q[FIELD_BITS-1]) begin
      mstep = fadd(mstep, ma_q, mod_q);
    end
  end

  always_comb begin
    unique case (ridx_q)
      3'd0:    raw_sel = crv_q;
      3'd1:    raw_sel = in_q.p_x;
      3'd2:    raw_sel = in_q.p_y;
      3'd3:    raw_sel = in_q.q_x;
      default: raw_sel = in_q.q_y;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (mod_q < THREE) ? S_FIN : S_RED_SET;
        end
      end
      S_RED_SET:   state_d = S_MUL;
      S_RED_STORE: state_d = (ridx_q == 3'd4) ? S_OP_SEL : S_RED_SET;
      S_OP_SEL:    state_d = (in_q.opcode == OP_ADD) ? S_PA_START : S_LOOP;
      S_LOOP:      state_d = in_q.scalar[i_q] ? S_PA_START : S_DBL_SET;
      S_ADD_DONE:  state_d = S_DBL_SET;
      S_DBL_SET:   state_d = S_PA_START;
      S_DBL_DONE:  state_d = (i_q == SCNT_BITS'(SCALAR_BITS - 1)) ? S_FIN : S_LOOP;
      S_PA_START: begin
        if (u_inf || v_inf || opp) begin
          state_d = pret_q;
        end else if (same) begin
          state_d = S_MUL;
        end else begin
          state_d = S_INV_INIT;
        end
      end
      S_PA_DBL2:   state_d = S_MUL;
      S_PA_DBL3:   state_d = S_MUL;
      S_PA_DEN:    state_d = S_INV_INIT;
      S_INV_INIT:  state_d = S_INV_SQ;
      S_INV_SQ:    state_d = S_MUL;
      S_INV_SQD: begin
        if (exp_m2[j_q]) begin
          state_d = S_MUL;
        end else begin
          state_d = (j_q == '0) ? S_SLOPE : S_INV_SQ;
        end
      end
      S_INV_MD:    state_d = (j_q == '0) ? S_SLOPE : S_INV_SQ;
      S_SLOPE:     state_d = S_MUL;
      S_SQ:        state_d = S_MUL;
      S_X1:        state_d = dbl_q ? S_MUL : S_X2A;
      S_X2D:       state_d = S_Y1;
      S_X2A:       state_d = S_Y1;
      S_Y1:        state_d = S_MUL;
      S_Y2:        state_d = pret_q;
      S_MUL:       state_d = (mcnt_q == FCNT_BITS'(FIELD_BITS - 1)) ? mret_q : S_MUL;
      S_FIN:       state_d = (!out_valid_q || out_ready_i) ? S_IDLE : S_FIN;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mret_d = mret_q; pret_d = pret_q; in_d = in_q; out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ar_d = ar_q; px_d = px_q; py_d = py_q; qx_d = qx_q; qy_d = qy_q;
    resx_d = resx_q; resy_d = resy_q; runx_d = runx_q; runy_d = runy_q;
    ux_d = ux_q; uy_d = uy_q; vx_d = vx_q; vy_d = vy_q; wx_d = wx_q; wy_d = wy_q;
    num_d = num_q; den_d = den_q; inv_d = inv_q; s_d = s_q; t_d = t_q;
    ma_d = ma_q; mb_d = mb_q; mr_d = mr_q; mcnt_d = mcnt_q;
    j_d = j_q; i_d = i_q; ridx_d = ridx_q; dbl_d = dbl_q; bad_d = bad_q;
    unique case (state_q)
      S_IDLE: begin
        in_d   = in_word_i;
        ridx_d = '0;
        bad_d  = mod_q < THREE;
      end
      S_RED_SET: begin
        ma_d = ONE; mb_d = raw_sel; mr_d = '0; mcnt_d = '0; mret_d = S_RED_STORE;
      end
      S_RED_STORE: begin
        unique case (ridx_q)
          3'd0:    ar_d = mr_q;
          3'd1:    px_d = mr_q;
          3'd2:    py_d = mr_q;
          3'd3:    qx_d = mr_q;
          default: qy_d = mr_q;
        endcase
        ridx_d = ridx_q + 3'd1;
      end
      S_OP_SEL: begin
        ux_d = px_q; uy_d = py_q; vx_d = qx_q; vy_d = qy_q; pret_d = S_FIN;
        resx_d = '0; resy_d = '0; runx_d = px_q; runy_d = py_q; i_d = '0;
      end
      S_LOOP: begin
        ux_d = resx_q; uy_d = resy_q; vx_d = runx_q; vy_d = runy_q; pret_d = S_ADD_DONE;
      end
      S_ADD_DONE: begin
        resx_d = wx_q; resy_d = wy_q;
      end
      S_DBL_SET: begin
        ux_d = runx_q; uy_d = runy_q; vx_d = runx_q; vy_d = runy_q; pret_d = S_DBL_DONE;
      end
      S_DBL_DONE: begin
        runx_d = wx_q; runy_d = wy_q; i_d = i_q + SCNT_BITS'(1);
      end
      S_PA_START: begin
        dbl_d = same;
        if (u_inf) begin
          wx_d = vx_q; wy_d = vy_q;
        end else if (v_inf) begin
          wx_d = ux_q; wy_d = uy_q;
        end else if (opp) begin
          wx_d = '0; wy_d = '0;
        end else begin
          num_d = fsub(uy_q, vy_q, mod_q);
          den_d = fsub(ux_q, vx_q, mod_q);
        end
        ma_d = ux_q; mb_d = ux_q; mr_d = '0; mcnt_d = '0; mret_d = S_PA_DBL2;
      end
      S_PA_DBL2: begin
        ma_d = THREE; mb_d = mr_q; mr_d = '0; mcnt_d = '0; mret_d = S_PA_DBL3;
      end
      S_PA_DBL3: begin
        num_d = fadd(mr_q, ar_q, mod_q);
        ma_d = TWO; mb_d = uy_q; mr_d = '0; mcnt_d = '0; mret_d = S_PA_DEN;
      end
      S_PA_DEN: begin
        den_d = mr_q;
      end
      S_INV_INIT: begin
        inv_d = ONE; j_d = FCNT_BITS'(FIELD_BITS - 1);
      end
      S_INV_SQ: begin
        ma_d = inv_q; mb_d = inv_q; mr_d = '0; mcnt_d = '0; mret_d = S_INV_SQD;
      end
      S_INV_SQD: begin
        inv_d = mr_q;
        ma_d = mr_q; mb_d = den_q; mr_d = '0; mcnt_d = '0; mret_d = S_INV_MD;
        if (!exp_m2[j_q]) begin
          j_d = j_q - FCNT_BITS'(1);
        end
      end
      S_INV_MD: begin
        inv_d = mr_q; j_d = j_q - FCNT_BITS'(1);
      end
      S_SLOPE: begin
        ma_d = num_q; mb_d = inv_q; mr_d = '0; mcnt_d = '0; mret_d = S_SQ;
      end
      S_SQ: begin
        s_d = mr_q;
        ma_d = mr_q; mb_d = mr_q; mr_d = '0; mcnt_d = '0; mret_d = S_X1;
      end
      S_X1: begin
        t_d = mr_q;
        wx_d = fsub(mr_q, ux_q, mod_q);
        ma_d = TWO; mb_d = ux_q; mr_d = '0; mcnt_d = '0; mret_d = S_X2D;
      end
      S_X2D: begin
        wx_d = fsub(t_q, mr_q, mod_q);
      end
      S_X2A: begin
        wx_d = fsub(wx_q, vx_q, mod_q);
      end
      S_Y1: begin
        ma_d = s_q; mb_d = fsub(ux_q, wx_q, mod_q); mr_d = '0; mcnt_d = '0;
        mret_d = S_Y2;
      end
      S_Y2: begin
        wy_d = fsub(mr_q, uy_q, mod_q);
      end
      S_MUL: begin
        mr_d   = mstep;
        mb_d   = mb_q << 1;
        mcnt_d = mcnt_q + FCNT_BITS'(1);
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (bad_q) begin
            out_d.result_x = '0; out_d.result_y = '0;
          end else if (in_q.opcode == OP_ADD) begin
            out_d.result_x = wx_q; out_d.result_y = wy_q;
          end else begin
            out_d.result_x = resx_q; out_d.result_y = resy_q;
          end
          out_d.at_infinity = (out_d.result_x == '0) && (out_d.result_y == '0);
        end
      end
      default: begin
        out_valid_d = out_valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mod_q       <= MODULUS_RESET;
      crv_q       <= CURVE_A_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_MODULUS: mod_q <= cfg_data_i;
          REG_CURVE_A: crv_q <= cfg_data_i;
          default:     mod_q <= mod_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mret_q <= mret_d; pret_q <= pret_d; in_q <= in_d; out_q <= out_d;
    ar_q <= ar_d; px_q <= px_d; py_q <= py_d; qx_q <= qx_d; qy_q <= qy_d;
    resx_q <= resx_d; resy_q <= resy_d; runx_q <= runx_d; runy_q <= runy_d;
    ux_q <= ux_d; uy_q <= uy_d; vx_q <= vx_d; vy_q <= vy_d; wx_q <= wx_d; wy_q <= wy_d;
    num_q <= num_d; den_q <= den_d; inv_q <= inv_d; s_q <= s_d; t_q <= t_d;
    ma_q <= ma_d; mb_q <= mb_d; mr_q <= mr_d; mcnt_q <= mcnt_d;
    j_q <= j_d; i_q <= i_d; ridx_q <= ridx_d; dbl_q <= dbl_d; bad_q <= bad_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Point unit testbench
// Drives point additions and scalar multiplies over several field settings,
// predicts each result with a behavioral affine curve model and compares it
// field by field, with random idling on both channels until the final phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import ecpa_pkg::*; ();

  typedef logic [FIELD_BITS-1:0] fe_t;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic      cfg_idx_i;
  fe_t       cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  fe_t       fld_mod;
  fe_t       fld_a;
  out_word_t expected_points[$];
  int        mismatch_cnt;
  bit        send_idle_en;
  bit        recv_idle_en;

  ec_point_add_scalar_multiply u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic fe_t m_add(fe_t a, fe_t b, fe_t m);
    logic [FIELD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[FIELD_BITS-1:0];
  endfunction

  function automatic fe_t m_sub(fe_t a, fe_t b, fe_t m);
    return (a >= b) ? fe_t'(a - b) : fe_t'(a + (m - b));
  endfunction

  function automatic fe_t m_mul(fe_t a, fe_t b, fe_t m);
    logic [2*FIELD_BITS-1:0] p;
    p = a * b;
    return fe_t'(p % m);
  endfunction

  function automatic fe_t m_inv(fe_t x, fe_t m);
    fe_t e;
    fe_t r;
    e = m - 2;
    r = 1;
    for (int i = FIELD_BITS - 1; i >= 0; i--) begin
      r = m_mul(r, r, m);
      if (e[i]) begin
        r = m_mul(r, x, m);
      end
    end
    return r;
  endfunction

  function automatic void point_sum(input fe_t px, py, qx, qy, m, a, output fe_t rx, ry);
    fe_t s;
    if (px == 0 && py == 0) begin
      rx = qx; ry = qy;
    end else if (qx == 0 && qy == 0) begin
      rx = px; ry = py;
    end else if (px == qx && py == m_sub(0, qy, m)) begin
      rx = 0; ry = 0;
    end else begin
      if (px == qx && py == qy) begin
        s = m_mul(m_add(m_mul(3, m_mul(px, px, m), m), a, m),
                  m_inv(m_mul(2, py, m), m), m);
        rx = m_sub(m_mul(s, s, m), m_mul(2, px, m), m);
      end else begin
        s = m_mul(m_sub(py, qy, m), m_inv(m_sub(px, qx, m), m), m);
        rx = m_sub(m_sub(m_mul(s, s, m), px, m), qx, m);
      end
      ry = m_sub(m_mul(s, m_sub(px, rx, m), m), py, m);
    end
  endfunction

  function automatic out_word_t curve_result(in_word_t w);
    out_word_t o;
    fe_t m, a, px, py, rx, ry, ux, uy;
    m  = fld_mod;
    rx = 0;
    ry = 0;
    if (m >= 3) begin
      a  = fld_a % m;
      px = w.p_x % m;
      py = w.p_y % m;
      if (w.opcode == OP_ADD) begin
        point_sum(px, py, w.q_x % m, w.q_y % m, m, a, rx, ry);
      end else begin
        for (int i = 0; i < SCALAR_BITS; i++) begin
          if (w.scalar[i]) begin
            point_sum(rx, ry, px, py, m, a, ux, uy);
            rx = ux; ry = uy;
          end
          point_sum(px, py, px, py, m, a, ux, uy);
          px = ux; py = uy;
        end
      end
    end
    o.result_x    = rx;
    o.result_y    = ry;
    o.at_infinity = (rx == 0 && ry == 0);
    return o;
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 18)) @(posedge clk_i);
  endtask

  task automatic send_word(input in_word_t w);
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      idle_burst();
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_points.insert(expected_points.size(), curve_result(w));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input fe_t val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_MODULUS) fld_mod = val;
    else fld_a = val;
  endtask

  function automatic in_word_t mk(opcode_e op, fe_t px, py, qx, qy, logic [15:0] k);
    in_word_t w;
    w.opcode = op;
    w.p_x = px; w.p_y = py; w.q_x = qx; w.q_y = qy; w.scalar = k;
    return w;
  endfunction

  function automatic fe_t rnd_elem();
    return (fld_mod >= 3 && $urandom_range(0, 7) != 0) ?
           fe_t'($urandom_range(0, fld_mod - 1)) : fe_t'($urandom);
  endfunction

  function automatic logic [15:0] rnd_scalar();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_word(mk(OP_ADD, 0, 0, 0, 0, 0));
    send_word(mk(OP_ADD, 0, 0, 5, 7, 16'hffff));
    send_word(mk(OP_ADD, 5, 7, 0, 0, 0));
    send_word(mk(OP_ADD, 5, 7, 5, 163 - 7, 0));
    send_word(mk(OP_ADD, 5, 0, 5, 0, 0));
    send_word(mk(OP_ADD, 5, 7, 5, 7, 0));
    send_word(mk(OP_ADD, 5, 7, 5, 9, 0));
    send_word(mk(OP_ADD, 5, 7, 9, 7, 0));
    send_word(mk(OP_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(mk(OP_ADD, 163, 163, 168, 170, 0));
    send_word(mk(OP_MUL, 5, 7, 16'hffff, 16'hffff, 0));
    send_word(mk(OP_MUL, 5, 7, 0, 0, 1));
    send_word(mk(OP_MUL, 5, 7, 0, 0, 2));
    send_word(mk(OP_MUL, 5, 7, 0, 0, 16'hffff));
    send_word(mk(OP_MUL, 5, 7, 0, 0, 16'h8000));
    send_word(mk(OP_MUL, 0, 0, 0, 0, 16'h1234));
    send_word(mk(OP_MUL, 16'hffff, 16'h0000, 0, 0, 16'haaaa));
  endtask

  task automatic test_random_phase(input int n);
    in_word_t w;
    fe_t px, py;
    for (int i = 0; i < n; i++) begin
      px = rnd_elem();
      py = rnd_elem();
      case ($urandom_range(0, 5))
        0: w = mk(OP_ADD, px, py, px, py, 16'($urandom));
        1: w = mk(OP_ADD, px, py, px, (fld_mod >= 3) ? m_sub(0, py % fld_mod, fld_mod)
                  : fe_t'($urandom), 16'($urandom));
        2, 3: w = mk(OP_ADD, px, py, rnd_elem(), rnd_elem(), 16'($urandom));
        default: w = mk(OP_MUL, px, py, fe_t'($urandom), fe_t'($urandom), rnd_scalar());
      endcase
      send_word(w);
    end
  endtask

  task automatic test_settings();
    write_reg(REG_MODULUS, 16'd65521);
    write_reg(REG_CURVE_A, 16'd65535);
    test_random_phase(20);
    write_reg(REG_MODULUS, 16'd3);
    write_reg(REG_CURVE_A, 16'd0);
    test_random_phase(12);
    write_reg(REG_MODULUS, 16'd2);
    test_random_phase(4);
    write_reg(REG_MODULUS, 16'd0);
    test_random_phase(3);
    write_reg(REG_MODULUS, 16'd91);
    write_reg(REG_CURVE_A, 16'd200);
    test_random_phase(10);
    write_reg(REG_MODULUS, 16'd257);
    write_reg(REG_CURVE_A, 16'($urandom));
    test_random_phase(40);
    write_reg(REG_MODULUS, 16'd163);
    write_reg(REG_CURVE_A, 16'd1);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random_phase(40);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("Unexpected word: %p", out_word_o);
      end else begin
        if (out_word_o.result_x !== expected_points[0].result_x ||
            out_word_o.result_y !== expected_points[0].result_y ||
            out_word_o.at_infinity !== expected_points[0].at_infinity) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("Mismatch: expected %p, actual %p", expected_points[0], out_word_o);
          end
        end
        void'(expected_points.pop_front());
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        idle_burst();
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #400ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_MODULUS;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    fld_mod      = MODULUS_RESET;
    fld_a        = CURVE_A_RESET;
    mismatch_cnt = 0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(20);
    test_settings();
    drain();
    if (mismatch_cnt == 0 && expected_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ecpa_pkg.sv
rtl/core/ec_point_add_scalar_multiply.sv
tb/tb.sv
